FILE: src/nocmp_pkg.sv
package nocmp_pkg;

  // Buffer depth per name and derived widths
  localparam int MAX_LEN = 256;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Which name a byte belongs to
  localparam logic NAME_FIRST  = 1'b0;
  localparam logic NAME_SECOND = 1'b1;

  // Comparison result codes
  localparam logic signed [1:0] ORD_LT = -2'sd1;
  localparam logic signed [1:0] ORD_EQ = 2'sd0;
  localparam logic signed [1:0] ORD_GT = 2'sd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_SCAN,
    ST_ZSKIP,
    ST_EQRUN,
    ST_KRUN,
    ST_RESULT
  } nocmp_state_t;

  function automatic logic is_dig(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: src/nocmp_ram.sv
module nocmp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/natural_order_name_compare.sv
// Natural-order comparator for two names.
//
// Request channel (req_valid/req_ready): one byte per transaction. req_type
// selects the first or second name, last_byte closes that name. A zero byte
// is not stored and ends the name; bytes past MAX_LEN are dropped and flagged.
// A name whose last byte was seen starts over on its next byte.
// Bytes load back to back while req_ready is high.
//
// The last byte of the second name starts the compare. req_ready then drops
// while a sequencer walks both name buffers, one byte position per cycle
// through the single read port of each buffer RAM: a priming step, a scan
// of byte positions up to a difference or the end of the shorter name, a
// leading-zero skip, equal-digit run and run-length step for each digit run
// met, and a final step to post the result.
//
// Response channel (rsp_valid/rsp_ready): one transaction per pair with the
// sign of the comparison in order and the truncation flag. The response sits
// in an output register; loading of the next pair goes on while it waits. A
// stalled receiver only holds the block once the next compare is finished.
//
// Reset (rst, synchronous) empties both names and clears the flag; buffer
// contents are not cleared, only bytes below each name's length are read.
module natural_order_name_compare
  import nocmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              req_type,
  input  logic [7:0]        name_byte,
  input  logic              last_byte,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic signed [1:0] order,
  output logic              truncated
);

  nocmp_state_t state, state_next;

  // Per-name load state
  logic [LEN_W-1:0] len_a, len_a_next, len_b, len_b_next;
  logic             ended_a, ended_a_next, ended_b, ended_b_next;
  logic             done_a, done_a_next, done_b, done_b_next;
  logic             ovf, ovf_next;

  // Scan pointers and saved first differing digits
  logic [LEN_W-1:0] pa, pa_next, pb, pb_next;
  logic [7:0]       da, da_next, db, db_next;
  logic signed [1:0] res_order, res_order_next;
  logic              rsp_valid_next;
  logic signed [1:0] order_next;
  logic              truncated_next;

  // Load-side datapath
  logic [LEN_W-1:0] cur_len, ld_base, ld_len;
  logic             cur_ended, cur_done, ld_ended, ld_wr, ovf_hit;
  logic             wr_a, wr_b;

  // Read data, masked beyond each length
  logic [7:0] rd_a, rd_b, ca, cb;
  logic       dig_a, dig_b;

  assign req_ready = (state == ST_LOAD);

  assign cur_len   = (req_type == NAME_SECOND) ? len_b   : len_a;
  assign cur_ended = (req_type == NAME_SECOND) ? ended_b : ended_a;
  assign cur_done  = (req_type == NAME_SECOND) ? done_b  : done_a;

  // A closed name restarts from empty on its next byte
  always_comb begin
    ld_base  = cur_done ? '0 : cur_len;
    ld_ended = cur_done ? 1'b0 : cur_ended;
    ld_wr    = 1'b0;
    ovf_hit  = 1'b0;
    ld_len   = ld_base;
    if (!ld_ended) begin
      if (name_byte == 8'd0) begin
        ld_ended = 1'b1;
      end else if (ld_base < LEN_W'(MAX_LEN)) begin
        ld_wr  = 1'b1;
        ld_len = ld_base + 1'b1;
      end else begin
        ovf_hit = 1'b1;
      end
    end
  end

  assign wr_a = req_valid && req_ready && (req_type == NAME_FIRST) && ld_wr;
  assign wr_b = req_valid && req_ready && (req_type == NAME_SECOND) && ld_wr;

  nocmp_ram #(.DEPTH(MAX_LEN), .WIDTH(8)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (ld_base[ADDR_W-1:0]),
    .wr_data (name_byte),
    .rd_addr (pa_next[ADDR_W-1:0]),
    .rd_data (rd_a)
  );

  nocmp_ram #(.DEPTH(MAX_LEN), .WIDTH(8)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (ld_base[ADDR_W-1:0]),
    .wr_data (name_byte),
    .rd_addr (pb_next[ADDR_W-1:0]),
    .rd_data (rd_b)
  );

  // Read address follows the next pointer, so data lines up with pa/pb
  assign ca    = (pa < len_a) ? rd_a : 8'd0;
  assign cb    = (pb < len_b) ? rd_b : 8'd0;
  assign dig_a = is_dig(ca);
  assign dig_b = is_dig(cb);

  always_comb begin
    state_next     = state;
    len_a_next     = len_a;
    len_b_next     = len_b;
    ended_a_next   = ended_a;
    ended_b_next   = ended_b;
    done_a_next    = done_a;
    done_b_next    = done_b;
    ovf_next       = ovf;
    pa_next        = pa;
    pb_next        = pb;
    da_next        = da;
    db_next        = db;
    res_order_next = res_order;
    rsp_valid_next = rsp_valid;
    order_next     = order;
    truncated_next = truncated;

    // Drop the response once taken
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_LOAD: begin
        pa_next = '0;
        pb_next = '0;
        if (req_valid) begin
          if (ovf_hit) begin
            ovf_next = 1'b1;
          end
          if (req_type == NAME_SECOND) begin
            len_b_next   = ld_len;
            ended_b_next = ld_ended;
            done_b_next  = last_byte;
            if (last_byte) begin
              state_next = ST_PRIME;
            end
          end else begin
            len_a_next   = ld_len;
            ended_a_next = ld_ended;
            done_a_next  = last_byte;
          end
        end
      end

      // Reissue address zero after the final write has landed
      ST_PRIME: begin
        pa_next    = '0;
        pb_next    = '0;
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        if ((ca == 8'd0) || (cb == 8'd0)) begin
          res_order_next = (ca != 8'd0) ? ORD_GT : ((cb != 8'd0) ? ORD_LT : ORD_EQ);
          state_next     = ST_RESULT;
        end else if (dig_a && dig_b) begin
          state_next = ST_ZSKIP;
        end else if (ca != cb) begin
          res_order_next = (ca < cb) ? ORD_LT : ORD_GT;
          state_next     = ST_RESULT;
        end else begin
          pa_next = pa + 1'b1;
          pb_next = pb + 1'b1;
        end
      end

      // Skip leading zeros on both sides independently
      ST_ZSKIP: begin
        if (ca == CH_ZERO) begin
          pa_next = pa + 1'b1;
        end
        if (cb == CH_ZERO) begin
          pb_next = pb + 1'b1;
        end
        if ((ca != CH_ZERO) && (cb != CH_ZERO)) begin
          state_next = ST_EQRUN;
        end
      end

      ST_EQRUN: begin
        if (dig_a && dig_b && (ca == cb)) begin
          pa_next = pa + 1'b1;
          pb_next = pb + 1'b1;
        end else if (dig_a && dig_b) begin
          da_next    = ca;
          db_next    = cb;
          state_next = ST_KRUN;
        end else if (dig_a) begin
          res_order_next = ORD_GT;
          state_next     = ST_RESULT;
        end else if (dig_b) begin
          res_order_next = ORD_LT;
          state_next     = ST_RESULT;
        end else if (pa != pb) begin
          res_order_next = (pa < pb) ? ORD_GT : ORD_LT;
          state_next     = ST_RESULT;
        end else begin
          state_next = ST_SCAN;
        end
      end

      // Longer digit run wins; equal length falls back to first difference
      ST_KRUN: begin
        if (dig_a && dig_b) begin
          pa_next = pa + 1'b1;
          pb_next = pb + 1'b1;
        end else begin
          if (dig_a) begin
            res_order_next = ORD_GT;
          end else if (dig_b) begin
            res_order_next = ORD_LT;
          end else begin
            res_order_next = (da < db) ? ORD_LT : ((da > db) ? ORD_GT : ORD_EQ);
          end
          state_next = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          order_next     = res_order;
          truncated_next = ovf;
          len_a_next     = '0;
          len_b_next     = '0;
          ended_a_next   = 1'b0;
          ended_b_next   = 1'b0;
          done_a_next    = 1'b0;
          done_b_next    = 1'b0;
          ovf_next       = 1'b0;
          state_next     = ST_LOAD;
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      len_a     <= '0;
      len_b     <= '0;
      ended_a   <= 1'b0;
      ended_b   <= 1'b0;
      done_a    <= 1'b0;
      done_b    <= 1'b0;
      ovf       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len_a     <= len_a_next;
      len_b     <= len_b_next;
      ended_a   <= ended_a_next;
      ended_b   <= ended_b_next;
      done_a    <= done_a_next;
      done_b    <= done_b_next;
      ovf       <= ovf_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Datapath registers hold without reset
  always_ff @(posedge clk) begin
    pa        <= pa_next;
    pb        <= pb_next;
    da        <= da_next;
    db        <= db_next;
    res_order <= res_order_next;
    order     <= order_next;
    truncated <= truncated_next;
  end

endmodule

FILE: src/nocmp_checker.sv
module nocmp_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              req_type,
  input logic [7:0]        name_byte,
  input logic              last_byte,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic signed [1:0] order,
  input logic              truncated
);

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(order) && $stable(truncated))
    else $error("response changed while stalled");

  // Only the three sign codes appear
  a_order_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (order != 2'b10))
    else $error("invalid order code");

  // Closing the second name starts a compare, so loading stops
  a_busy_after_close: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type && last_byte |=> !req_ready)
    else $error("request accepted right after second name closed");

  // A new response only comes out of a compare
  a_rsp_from_compare: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response appeared while loading");

endmodule

bind natural_order_name_compare nocmp_checker u_nocmp_checker (.*);
